### rtl/core/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg: shared types and constants for the wildcard byte signature scan
// Register map codes and the bundles passed between the top level and the
// window compare unit.
// ----------------------------------------------------------------------------
package wbss_pkg;

	// Pattern storage is fixed at sixteen bytes by the register map
	localparam int CFG_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	// Register indexes; byte address is 8 * index
	typedef enum logic [1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_CARE     = 2'd2,
		REG_LEN      = 2'd3
	} reg_idx_t;

	// Pattern configuration as seen by the compare unit
	typedef struct packed {
		logic [8*CFG_BYTES-1:0] pattern;
		logic [CFG_BYTES-1:0]   care;
		logic [LEN_W-1:0]       length;
	} match_cfg_t;

	// Compare result: hit and the effective pattern length
	typedef struct packed {
		logic             hit;
		logic [LEN_W-1:0] length;
	} match_res_t;

endpackage

### rtl/core/wildcard_byte_signature_scan.sv
// A word accepted into the window register and stage one then passes to the
// output register, which raises m_tvalid. Throughput: one byte per cycle while
// the two-word output buffer has a free skid slot; the masked window compare is
// combinational between the window register and the output register.
// Reset clears the window, fill count, found latch, pattern registers and
// all valid flags.
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan: streaming wildcard pattern search
// Shifts each byte of a memory region into a window, compares the window with
// a masked pattern and reports the first match of a scan with its address.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan #(
	parameter int PATTERN_MAX  = 16,
	parameter int ADDRESS_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata: data_byte[7:0], byte_address, zero fill to whole bytes
	input  logic [((8+ADDRESS_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: region_start[0], new_scan[1]
	input  logic [1:0]                       s_tuser,
	// master stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: match_address, zero fill to whole bytes
	output logic [((ADDRESS_BITS+7)/8)*8-1:0] m_tdata,
	// tuser: match_found[0]
	output logic [0:0]                       m_tuser,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wbss_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [wbss_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [wbss_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import wbss_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_MAX+1);
	localparam int OUT_W  = ((ADDRESS_BITS+7)/8)*8;

	// configuration registers
	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [CFG_BYTES-1:0] care_q;
	logic [LEN_W-1:0]     len_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	// window state
	logic [7:0]              win_q [PATTERN_MAX];
	logic [FILL_W-1:0]       fill_q;
	logic                    found_q;
	logic [8*PATTERN_MAX-1:0] win_flat;

	// stage one
	logic                    valid_s1;
	logic                    fresh_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;

	// output buffer
	logic                    m_valid_q;
	logic                    m_found_q;
	logic [ADDRESS_BITS-1:0] m_addr_q;
	logic                    sk_valid_q;
	logic                    sk_found_q;
	logic [ADDRESS_BITS-1:0] sk_addr_q;

	// datapath
	logic                    accept;
	logic                    push;
	logic                    pop;
	logic [7:0]              in_data;
	logic                    in_start;
	logic                    in_fresh;
	match_cfg_t              mcfg;
	match_res_t              mres;
	logic                    hit;
	logic [ADDRESS_BITS-1:0] hit_addr;

	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PAT_LOW:  pat_low_q  <= pwdata[63:0];
				REG_PAT_HIGH: pat_high_q <= pwdata[63:0];
				REG_CARE:     care_q     <= pwdata[CFG_BYTES-1:0];
				REG_LEN:      len_q      <= pwdata[LEN_W-1:0];
				default:      len_q      <= len_q;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_PAT_LOW:  prdata = CFG_DATA_W'(pat_low_q);
			REG_PAT_HIGH: prdata = CFG_DATA_W'(pat_high_q);
			REG_CARE:     prdata = CFG_DATA_W'(care_q);
			REG_LEN:      prdata = CFG_DATA_W'(len_q);
			default:      prdata = '0;
		endcase
	end

	// handshake: stage one moves on while the skid slot is free
	assign s_tready = !valid_s1 || !sk_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign push     = valid_s1 && !sk_valid_q;
	assign pop      = m_valid_q && m_tready;

	assign in_data  = s_tdata[7:0];
	assign in_start = s_tuser[0];
	assign in_fresh = s_tuser[1];

	// shift the byte into the window, restarting on a new region or scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= '0;
			end
			fill_q <= '0;
		end else if (accept) begin
			win_q[0] <= in_data;
			if (in_start || in_fresh) begin
				for (int i = 1; i < PATTERN_MAX; i++) begin
					win_q[i] <= '0;
				end
				fill_q <= FILL_W'(1);
			end else begin
				for (int i = 1; i < PATTERN_MAX; i++) begin
					win_q[i] <= win_q[i-1];
				end
				if (fill_q != FILL_W'(PATTERN_MAX)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// stage one control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fresh_s1 <= in_fresh;
			addr_s1  <= s_tdata[8 +: ADDRESS_BITS];
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_flat[i*8 +: 8] = win_q[i];
		end
	end

	assign mcfg.pattern = {pat_high_q, pat_low_q};
	assign mcfg.care    = care_q;
	assign mcfg.length  = len_q;

	wbss_match #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_match (
		.cfg    (mcfg),
		.window (win_flat),
		.fill   (fill_q),
		.res    (mres)
	);

	// suppress after the first hit unless this word opens a new scan
	assign hit      = mres.hit && (fresh_s1 || !found_q);
	assign hit_addr = hit ? (addr_s1 - ADDRESS_BITS'(mres.length) + ADDRESS_BITS'(1)) : '0;

	// found latch advances when the word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (push) begin
			if (hit) begin
				found_q <= 1'b1;
			end else if (fresh_s1) begin
				found_q <= 1'b0;
			end
		end
	end

	// output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else begin
			if (pop && sk_valid_q) begin
				sk_valid_q <= 1'b0;
			end else if (pop && !push) begin
				m_valid_q <= 1'b0;
			end else if (push && !pop && m_valid_q) begin
				sk_valid_q <= 1'b1;
			end else if (push) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && sk_valid_q) begin
			m_found_q <= sk_found_q;
			m_addr_q  <= sk_addr_q;
		end else if (push && (pop || !m_valid_q)) begin
			m_found_q <= hit;
			m_addr_q  <= hit_addr;
		end
		if (push && !pop && m_valid_q) begin
			sk_found_q <= hit;
			sk_addr_q  <= hit_addr;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = OUT_W'(m_addr_q);
	assign m_tuser[0] = m_found_q;

endmodule

### rtl/core/wbss_match.sv
// ----------------------------------------------------------------------------
// wbss_match: masked window compare
// Checks the newest bytes of the window against the configured pattern,
// skipping wildcard positions, once enough bytes of the region are held.
// ----------------------------------------------------------------------------
module wbss_match #(
	parameter int PATTERN_MAX = 16
) (
	input  wbss_pkg::match_cfg_t           cfg,
	input  logic [8*PATTERN_MAX-1:0]       window,
	input  logic [$clog2(PATTERN_MAX+1)-1:0] fill,
	output wbss_pkg::match_res_t           res
);
	import wbss_pkg::*;

	localparam int LIM    = (PATTERN_MAX < CFG_BYTES) ? PATTERN_MAX : CFG_BYTES;
	localparam int FILL_W = $clog2(PATTERN_MAX+1);
	localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
	localparam int IDX_W  = $clog2(CFG_BYTES);

	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] pos;
	logic [IDX_W-1:0] pidx;
	logic             miss;

	// Clamp the configured length to the compare width
	always_comb begin
		if (cfg.length > LEN_W'(LIM)) begin
			len = LEN_W'(LIM);
		end else begin
			len = cfg.length;
		end
	end

	// Window byte k (newest first) lines up with pattern byte len-1-k
	always_comb begin
		miss = 1'b0;
		pos  = '0;
		pidx = '0;
		for (int k = 0; k < LIM; k++) begin
			pos  = len - LEN_W'(1) - LEN_W'(k);
			pidx = pos[IDX_W-1:0];
			if ((LEN_W'(k) < len) && cfg.care[pidx] &&
			    (cfg.pattern[pidx*8 +: 8] != window[k*8 +: 8])) begin
				miss = 1'b1;
			end
		end
	end

	assign res.hit    = (len != '0) && (CMP_W'(fill) >= CMP_W'(len)) && !miss;
	assign res.length = len;

endmodule
